@@ design/lpp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared constants, codes and types of the lattice predator-prey update block.
// ----------------------------------------------------------------------------
package lpp_pkg;

  // lattice geometry
  localparam int WIDTH_X     = 256;
  localparam int HEIGHT_Y    = 256;
  localparam int LAYERS_Z    = 1;
  localparam int NUM_SPECIES = 3;

  localparam int CELL_TOTAL = WIDTH_X * HEIGHT_Y * LAYERS_Z;
  localparam int ADDR_W     = $clog2(CELL_TOTAL);
  localparam int CELL_W     = 2;
  localparam int CNT_W      = 17;
  localparam int SUCC_W     = $clog2(CELL_TOTAL + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREY_ONE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREY_TWO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREY_THR = 3'd4;

  // request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  // neighbor directions
  localparam logic [2:0] DIR_XP = 3'd0;
  localparam logic [2:0] DIR_XM = 3'd1;
  localparam logic [2:0] DIR_YP = 3'd2;
  localparam logic [2:0] DIR_YM = 3'd3;
  localparam logic [2:0] DIR_ZP = 3'd4;
  localparam logic [2:0] DIR_ZM = 3'd5;

  // event results
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_LOADED = 3'd1;
  localparam logic [2:0] EV_MOVED  = 3'd2;
  localparam logic [2:0] EV_PRED   = 3'd3;
  localparam logic [2:0] EV_REPRO  = 3'd4;

  // configuration register contents
  typedef struct packed {
    logic [CNT_W-1:0]     move_thr;
    logic [CNT_W-1:0]     pred_thr;
    logic [CFG_DAT_W-1:0] prey_one;
    logic [CFG_DAT_W-1:0] prey_two;
    logic [CFG_DAT_W-1:0] prey_three;
  } cfg_t;

  // population counter update
  typedef struct packed {
    logic              en;
    logic              inc_en;
    logic [CELL_W-1:0] inc_sp;
    logic              dec_en;
    logic [CELL_W-1:0] dec_sp;
    logic              success;
  } cnt_upd_t;

  typedef logic [3:0][CNT_W-1:0] cnt_arr_t;

endpackage

@@ design/lattice_predator_prey_update.sv @@
// ----------------------------------------------------------------------------
// lattice_predator_prey_update
// Monte Carlo event engine on a periodic lattice held in one memory.
// ----------------------------------------------------------------------------
// Sequence: a request is captured on accept and its event executes in S_EXEC
//   once the result register is free; the input stalls until then, and through
//   the second cell write of a swap, as the lattice memory has a single write port.
// Reset: a clearing pass writes all 65536 (CELL_TOTAL) cells to empty, one per
//   cycle, with the input stalled; configuration writes are taken throughout.
module lattice_predator_prey_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lpp_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [7:0]                    col_i,
  input  logic [7:0]                    row_i,
  input  logic [3:0]                    layer_i,
  input  logic [1:0]                    species_i,
  input  logic [2:0]                    direction_i,
  input  logic [15:0]                   action_draw_i,
  input  logic [15:0]                   prey_draw_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    event_res_o,
  output logic                          generation_end_o,
  output logic [lpp_pkg::CNT_W-1:0]     empty_count_o,
  output logic [lpp_pkg::CNT_W-1:0]     count_one_o,
  output logic [lpp_pkg::CNT_W-1:0]     count_two_o,
  output logic [lpp_pkg::CNT_W-1:0]     count_three_o
);
  import lpp_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SWAP
  } state_e;

  localparam logic [7:0] X_LAST = 8'(WIDTH_X - 1);
  localparam logic [7:0] Y_LAST = 8'(HEIGHT_Y - 1);
  localparam logic [3:0] Z_LAST = 4'(LAYERS_Z - 1);

  function automatic logic [ADDR_W-1:0] cell_index(logic [7:0] x, logic [7:0] y,
                                                    logic [3:0] z);
    return ADDR_W'(ADDR_W'(z) * ADDR_W'(WIDTH_X * HEIGHT_Y)
                 + ADDR_W'(y) * ADDR_W'(WIDTH_X) + ADDR_W'(x));
  endfunction

  function automatic logic [15:0] prey_prob(cfg_t c, logic [CELL_W-1:0] pred,
                                            logic [CELL_W-1:0] prey);
    logic [CFG_DAT_W-1:0] r;
    logic [15:0]          p;
    case (pred)
      2'd1:    r = c.prey_one;
      2'd2:    r = c.prey_two;
      2'd3:    r = c.prey_three;
      default: r = '0;
    endcase
    case (prey)
      2'd1:    p = r[15:0];
      2'd2:    p = r[31:16];
      2'd3:    p = r[47:32];
      default: p = '0;
    endcase
    return p;
  endfunction

  state_e            state_q;
  logic [ADDR_W-1:0] clr_q;
  logic              out_valid_q;
  logic [2:0]        event_res_q;
  logic              kind_q;
  logic              coord_ok_q;
  logic              sp_ok_q;
  logic              dir_ok_q;
  logic [CELL_W-1:0] sp_q;
  logic [15:0]       adraw_q;
  logic [15:0]       pdraw_q;
  logic [ADDR_W-1:0] ac_q;
  logic [ADDR_W-1:0] ps_q;

  cfg_t              cfg;
  cnt_upd_t          upd;
  cnt_arr_t          cnt;
  logic              gen;

  logic              accept;
  logic              fire;
  logic              coord_ok;
  logic [7:0]        nx, ny;
  logic [3:0]        nz;
  logic [ADDR_W-1:0] ac_addr, ps_addr;
  logic [CELL_W-1:0] me, victim;

  logic              ex_we;
  logic [ADDR_W-1:0] ex_waddr;
  logic [CELL_W-1:0] ex_wdata;
  logic [2:0]        ex_res;
  logic              ex_swap;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  // configuration registers
  lpp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // request handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  // chosen cell check and wrapping neighbor
  assign coord_ok = ({1'b0, col_i} < 9'(WIDTH_X)) && ({1'b0, row_i} < 9'(HEIGHT_Y))
                 && ({1'b0, layer_i} < 5'(LAYERS_Z));

  always_comb begin
    nx = col_i;
    ny = row_i;
    nz = layer_i;
    case (direction_i)
      DIR_XP:  nx = (col_i == X_LAST) ? 8'd0 : col_i + 8'd1;
      DIR_XM:  nx = (col_i == 8'd0) ? X_LAST : col_i - 8'd1;
      DIR_YP:  ny = (row_i == Y_LAST) ? 8'd0 : row_i + 8'd1;
      DIR_YM:  ny = (row_i == 8'd0) ? Y_LAST : row_i - 8'd1;
      DIR_ZP:  nz = (layer_i == Z_LAST) ? 4'd0 : layer_i + 4'd1;
      DIR_ZM:  nz = (layer_i == 4'd0) ? Z_LAST : layer_i - 4'd1;
      default: ;
    endcase
  end

  assign ac_addr = cell_index(col_i, row_i, layer_i);
  assign ps_addr = cell_index(nx, ny, nz);

  // lattice memory, both cells read on accept
  lpp_lattice_ram #(
    .DEPTH  (CELL_TOTAL),
    .DATA_W (CELL_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (accept),
    .raddr_a_i (ac_addr),
    .raddr_b_i (ps_addr),
    .rdata_a_o (me),
    .rdata_b_o (victim)
  );

  // event outcome from the two cells read
  always_comb begin
    ex_we    = 1'b0;
    ex_waddr = ps_q;
    ex_wdata = me;
    ex_res   = EV_NONE;
    ex_swap  = 1'b0;
    upd      = '0;
    upd.en   = fire;
    if (kind_q == KIND_LOAD) begin
      if (coord_ok_q && sp_ok_q) begin
        ex_we      = 1'b1;
        ex_waddr   = ac_q;
        ex_wdata   = sp_q;
        ex_res     = EV_LOADED;
        upd.dec_en = 1'b1;
        upd.dec_sp = me;
        upd.inc_en = 1'b1;
        upd.inc_sp = sp_q;
      end
    end else if (coord_ok_q && (me != '0) && dir_ok_q) begin
      if ({1'b0, adraw_q} < cfg.move_thr) begin
        // swap: neighbor gets the mover now, chosen cell next cycle
        ex_we   = 1'b1;
        ex_res  = EV_MOVED;
        ex_swap = 1'b1;
      end else if ({1'b0, adraw_q} < cfg.pred_thr) begin
        if ((victim != '0) && (pdraw_q < prey_prob(cfg, me, victim))) begin
          ex_we      = 1'b1;
          ex_wdata   = '0;
          ex_res     = EV_PRED;
          upd.dec_en = 1'b1;
          upd.dec_sp = victim;
          upd.inc_en = 1'b1;
          upd.inc_sp = '0;
        end
      end else if (victim == '0) begin
        ex_we      = 1'b1;
        ex_res     = EV_REPRO;
        upd.inc_en = 1'b1;
        upd.inc_sp = me;
        upd.dec_en = 1'b1;
        upd.dec_sp = '0;
      end
    end
    upd.success = fire && (ex_res != EV_NONE) && (ex_res != EV_LOADED);
  end

  // memory write select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ex_waddr;
    mem_wdata = ex_wdata;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      S_EXEC: begin
        mem_we = fire && ex_we;
      end
      S_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = ac_q;
        mem_wdata = victim;
      end
      default: ;
    endcase
  end

  // population and generation counters
  lpp_counts u_counts (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .cnt_o  (cnt),
    .gen_o  (gen)
  );

  // sequencer, request capture and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      event_res_q <= EV_NONE;
      kind_q      <= KIND_LOAD;
      coord_ok_q  <= 1'b0;
      sp_ok_q     <= 1'b0;
      dir_ok_q    <= 1'b0;
      sp_q        <= '0;
      adraw_q     <= '0;
      pdraw_q     <= '0;
      ac_q        <= '0;
      ps_q        <= '0;
    end else begin
      // result valid, a new result may replace one being taken
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(CELL_TOTAL - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_q     <= kind_i;
            coord_ok_q <= coord_ok;
            sp_ok_q    <= (species_i <= 2'(NUM_SPECIES));
            dir_ok_q   <= (direction_i <= DIR_ZM);
            sp_q       <= species_i;
            adraw_q    <= action_draw_i;
            pdraw_q    <= prey_draw_i;
            ac_q       <= ac_addr;
            ps_q       <= ps_addr;
            state_q    <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            event_res_q <= ex_res;
            state_q     <= ex_swap ? S_SWAP : S_IDLE;
          end
        end
        S_SWAP: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = event_res_q;
  assign generation_end_o = gen;
  assign empty_count_o    = cnt[0];
  assign count_one_o      = cnt[1];
  assign count_two_o      = cnt[2];
  assign count_three_o    = cnt[3];

`ifndef SYNTH
  // the second swap write only follows an executed event
  a_swap_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWAP |-> $past(state_q) == S_EXEC)
    else $error("swap write without a preceding event");

  // a blocked event waits and leaves the pending result alone
  a_exec_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_valid_q && out_stall_i)
      |=> (state_q == S_EXEC && $stable(event_res_q)))
    else $error("event executed while the result register was blocked");

  // a generation ends only on a successful event
  a_gen_on_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && generation_end_o)
      |-> (event_res_q == EV_MOVED || event_res_q == EV_PRED || event_res_q == EV_REPRO))
    else $error("generation end flagged without a successful event");
`endif

endmodule

@@ design/lpp_lattice_ram.sv @@
// ----------------------------------------------------------------------------
// lpp_lattice_ram
// Generic memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lpp_lattice_ram #(
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 2,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

@@ design/lpp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lpp_cfg_regs
// Configuration register file: thresholds and predation probability rows.
// ----------------------------------------------------------------------------
module lpp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lpp_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output lpp_pkg::cfg_t                 cfg_o
);
  import lpp_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MOVE_THR: cfg_q.move_thr   <= cfg_data_i[CNT_W-1:0];
        CFG_PRED_THR: cfg_q.pred_thr   <= cfg_data_i[CNT_W-1:0];
        CFG_PREY_ONE: cfg_q.prey_one   <= cfg_data_i;
        CFG_PREY_TWO: cfg_q.prey_two   <= cfg_data_i;
        CFG_PREY_THR: cfg_q.prey_three <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

@@ design/lpp_counts.sv @@
// ----------------------------------------------------------------------------
// lpp_counts
// Population counters per species and success counter with generation flag.
// ----------------------------------------------------------------------------
module lpp_counts (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpp_pkg::cnt_upd_t upd_i,
  output lpp_pkg::cnt_arr_t cnt_o,
  output logic              gen_o
);
  import lpp_pkg::*;

  cnt_arr_t          cnt_q, cnt_d;
  logic [SUCC_W-1:0] succ_q, succ_d;
  logic [SUCC_W-1:0] succ_inc;
  logic              gen_q, gen_d;

  // per-species add and subtract
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cnt_d[k] = cnt_q[k]
               + CNT_W'(upd_i.inc_en && (upd_i.inc_sp == CELL_W'(k)))
               - CNT_W'(upd_i.dec_en && (upd_i.dec_sp == CELL_W'(k)));
    end
  end

  // success count wraps at the cell total
  assign succ_inc = succ_q + SUCC_W'(1);

  always_comb begin
    succ_d = succ_q;
    gen_d  = 1'b0;
    if (upd_i.success) begin
      if (succ_inc == SUCC_W'(CELL_TOTAL)) begin
        succ_d = '0;
        gen_d  = 1'b1;
      end else begin
        succ_d = succ_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= {{(3*CNT_W){1'b0}}, CNT_W'(CELL_TOTAL)};
      succ_q <= '0;
      gen_q  <= 1'b0;
    end else if (upd_i.en) begin
      cnt_q  <= cnt_d;
      succ_q <= succ_d;
      gen_q  <= gen_d;
    end
  end

  assign cnt_o = cnt_q;
  assign gen_o = gen_q;

`ifndef SYNTH
  // every update moves cells between classes, the total stays fixed
  a_cells_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(cnt_q[0] + cnt_q[1] + cnt_q[2] + cnt_q[3]) == CNT_W'(CELL_TOTAL))
    else $error("population counts do not add up to the cell total");
`endif

endmodule
